>>> rtl/ess_pkg.sv
// shared types and constants for the elevator seek scheduler
// no dependencies

package ess_pkg;

    localparam int MAX_REQUESTS = 16;
    localparam int TRACK_W      = 12;
    localparam int TOTAL_W      = 16;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_START_TRACK = APB_ADDR_W'(0);
    localparam logic [TRACK_W-1:0]    START_RESET      = TRACK_W'(100);
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX        = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               last;
    } req_beat_t;

    typedef struct packed {
        logic [TRACK_W-1:0] served_track;
        logic [TRACK_W-1:0] seek_distance;
        logic [TOTAL_W-1:0] total_movement;
        logic               last_served;
    } rsp_beat_t;

endpackage

>>> rtl/elevator_seek_scheduler.sv
// elevator seek scheduler: collects a batch of track requests, serves them in scan order
// request store held in a synchronous memory, scanned once per served track
// depends on ess_pkg
//
// usage: request beats (track, last) enter on req_valid/req_ready and are stored until
// a beat flagged last closes the batch; requests beyond MAX_REQUESTS are dropped, but a
// dropped last still closes the batch. no request beat is taken while a batch is served.
// each served track gives one rsp beat with the track, the seek distance, the running
// total (saturating) and last_served on the final beat of the batch.
// timing: for each result the block reads all n pending entries from the memory, one per
// cycle, through its single read port, n being the entries still pending.
// stall: while rsp_ready is low the pending result holds, the next scan still runs and
// then waits for the output register to drain.
// reset: store empty, start_track back to 100, outputs invalid. start_track is written
// over the apb port and takes effect when the next batch closes.

module elevator_seek_scheduler
    import ess_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_beat_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_beat_t             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_EMIT    = 2'd2;

    logic [TRACK_W-1:0] mem [MAX_REQUESTS];

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TRACK_W-1:0] start_reg;
    logic [TRACK_W-1:0] head_reg, head_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [IDX_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [TRACK_W-1:0] rd_data_reg;

    logic               up_found_reg, up_found_next;
    logic [TRACK_W-1:0] up_val_reg, up_val_next;
    logic [IDX_W-1:0]   up_idx_reg, up_idx_next;
    logic [TRACK_W-1:0] max_val_reg, max_val_next;
    logic [IDX_W-1:0]   max_idx_reg, max_idx_next;
    logic [TRACK_W-1:0] tail_val_reg, tail_val_next;

    logic               rsp_valid_reg, rsp_valid_next;
    rsp_beat_t          rsp_reg, rsp_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [TRACK_W-1:0] wr_data;

    logic               req_fire;
    logic               cfg_wr;
    logic [IDX_W-1:0]   tail_idx;
    logic               emit_go;
    logic [TRACK_W-1:0] sel_val;
    logic [IDX_W-1:0]   sel_idx;
    logic [TRACK_W-1:0] seek_dist;
    logic [TOTAL_W:0]   sum;

    assign req_ready = (state_reg == S_COLLECT);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_START_TRACK);
    assign prdata = (paddr == ADDR_START_TRACK) ? APB_DATA_W'(start_reg) : '0;

    assign tail_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign emit_go   = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp_ready);
    assign sel_val   = up_found_reg ? up_val_reg : max_val_reg;
    assign sel_idx   = up_found_reg ? up_idx_reg : max_idx_reg;
    assign seek_dist = (sel_val >= head_reg) ? (sel_val - head_reg) : (head_reg - sel_val);
    assign sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(seek_dist);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        total_next      = total_reg;
        issue_idx_next  = issue_idx_reg;
        issue_done_next = issue_done_reg;
        up_found_next   = up_found_reg;
        up_val_next     = up_val_reg;
        up_idx_next     = up_idx_reg;
        max_val_next    = max_val_reg;
        max_idx_next    = max_idx_reg;
        tail_val_next   = tail_val_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[IDX_W-1:0];
        wr_data         = req.track;

        unique case (state_reg)
            S_COLLECT:
            begin
                if (req_fire)
                begin
                    if (cnt_reg < CNT_W'(MAX_REQUESTS))
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (req.last)
                    begin
                        head_next       = start_reg;
                        total_next      = '0;
                        issue_idx_next  = '0;
                        issue_done_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                    if (issue_idx_reg == tail_idx)
                        issue_done_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    // nearest strictly above the head, first index on ties
                    if ((rd_data_reg > head_reg) &&
                        ((rd_idx_reg == '0) || !up_found_reg || (rd_data_reg < up_val_reg)))
                    begin
                        up_found_next = 1'b1;
                        up_val_next   = rd_data_reg;
                        up_idx_next   = rd_idx_reg;
                    end
                    else if (rd_idx_reg == '0)
                    begin
                        up_found_next = 1'b0;
                    end
                    // highest overall, last index on ties
                    if ((rd_idx_reg == '0) || (rd_data_reg >= max_val_reg))
                    begin
                        max_val_next = rd_data_reg;
                        max_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == tail_idx)
                    begin
                        tail_val_next = rd_data_reg;
                        state_next    = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    wr_en                      = 1'b1;
                    wr_addr                    = sel_idx;
                    wr_data                    = tail_val_reg;
                    cnt_next                   = cnt_reg - CNT_W'(1);
                    head_next                  = sel_val;
                    total_next                 = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    rsp_valid_next             = 1'b1;
                    rsp_next.served_track      = sel_val;
                    rsp_next.seek_distance     = seek_dist;
                    rsp_next.total_movement    = total_next;
                    rsp_next.last_served       = (cnt_reg == CNT_W'(1));
                    issue_idx_next             = '0;
                    issue_done_next            = 1'b0;
                    state_next                 = (cnt_reg == CNT_W'(1)) ? S_COLLECT : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // request store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[issue_idx_reg];
        rd_idx_reg  <= issue_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_COLLECT;
            cnt_reg        <= '0;
            start_reg      <= START_RESET;
            head_reg       <= START_RESET;
            total_reg      <= '0;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            up_found_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            total_reg      <= total_next;
            issue_idx_reg  <= issue_idx_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= (state_reg == S_SCAN) && !issue_done_reg;
            up_found_reg   <= up_found_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_wr)
                start_reg <= pwdata[TRACK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        up_val_reg   <= up_val_next;
        up_idx_reg   <= up_idx_next;
        max_val_reg  <= max_val_next;
        max_idx_reg  <= max_idx_next;
        tail_val_reg <= tail_val_next;
        rsp_reg      <= rsp_next;
    end

endmodule

>>> verif/elevator_seek_scheduler_checker.sv
`timescale 1ns / 1ps
// result checker for the elevator seek scheduler: watches request, result and apb beats,
// works out the scan order of every closed batch and compares each result beat
// depends on ess_pkg

module elevator_seek_scheduler_checker
    import ess_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_beat_t             req,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rsp_beat_t             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    logic [TRACK_W-1:0] start_track;
    logic [TRACK_W-1:0] queued_tracks [MAX_REQUESTS];
    int                 queued_count;
    int                 miss_count;
    rsp_beat_t          due_beats [$];
    rsp_beat_t          due_beat;

    task automatic schedule_batch();
        logic [TRACK_W-1:0] head;
        logic [TRACK_W-1:0] picked;
        logic [TRACK_W-1:0] seek_dist;
        int                 pick;
        int                 k;
        int                 total;
        rsp_beat_t          beat;
        head  = start_track;
        total = 0;
        while (queued_count > 0)
        begin
            pick = -1;
            for (k = 0; k < queued_count; k++)
                if (queued_tracks[k] > head
                    && (pick < 0 || queued_tracks[k] < queued_tracks[pick]))
                    pick = k;
            // nothing above the head: turn round and take the highest left
            if (pick < 0)
            begin
                pick = 0;
                for (k = 1; k < queued_count; k++)
                    if (queued_tracks[k] >= queued_tracks[pick])
                        pick = k;
            end
            picked = queued_tracks[pick];
            queued_count--;
            queued_tracks[pick] = queued_tracks[queued_count];
            seek_dist = (picked >= head) ? picked - head : head - picked;
            total     = total + int'(seek_dist);
            if (total > int'(TOTAL_MAX))
                total = int'(TOTAL_MAX);
            head = picked;
            beat.served_track   = picked;
            beat.seek_distance  = seek_dist;
            beat.total_movement = TOTAL_W'(total);
            beat.last_served    = (queued_count == 0);
            due_beats.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_track  = START_RESET;
            queued_count = 0;
            miss_count   = 0;
            due_beats.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_START_TRACK)
                start_track = pwdata[TRACK_W-1:0];
            if (rsp_valid && rsp_ready)
            begin
                if (due_beats.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("unexpected result beat: track %0d seek %0d total %0d last %0b",
                                 rsp.served_track, rsp.seek_distance, rsp.total_movement,
                                 rsp.last_served);
                end
                else
                begin
                    due_beat = due_beats.pop_front();
                    if (rsp.served_track !== due_beat.served_track
                        || rsp.seek_distance !== due_beat.seek_distance
                        || rsp.total_movement !== due_beat.total_movement
                        || rsp.last_served !== due_beat.last_served)
                    begin
                        miss_count++;
                        if (miss_count <= 10)
                            $display("result mismatch: expected track %0d seek %0d ",
                                     "total %0d last %0b, got track %0d seek %0d ",
                                     "total %0d last %0b",
                                     due_beat.served_track, due_beat.seek_distance,
                                     due_beat.total_movement, due_beat.last_served,
                                     rsp.served_track, rsp.seek_distance,
                                     rsp.total_movement, rsp.last_served);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                // a full store drops the track, but a dropped last still closes the batch
                if (queued_count < MAX_REQUESTS)
                begin
                    queued_tracks[queued_count] = req.track;
                    queued_count++;
                end
                if (req.last)
                    schedule_batch();
            end
            mismatches  <= miss_count;
            outstanding <= due_beats.size();
        end
    end

endmodule

>>> verif/elevator_seek_scheduler_test.sv
`timescale 1ns / 1ps
// testbench top for the elevator seek scheduler: drives request batches and apb writes
// with random gaps and result stalls, and gives the verdict from the checker's count
// depends on ess_pkg, elevator_seek_scheduler and elevator_seek_scheduler_checker

module elevator_seek_scheduler_test;
    import ess_pkg::*;

    localparam int                    WATCHDOG_LIMIT = 3000;
    localparam int                    SETTLE_CYCLES  = 40;
    localparam int                    RANDOM_ITEMS   = 200;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED    = APB_ADDR_W'(4);
    localparam logic [TRACK_W-1:0]    TRACK_TOP      = {TRACK_W{1'b1}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_beat_t             req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_beat_t             rsp;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    outstanding;
    int                    quiet_cycles = 0;
    int                    rsp_hold     = 0;
    int                    hold_draw;
    bit                    req_calm     = 1'b0;
    bit                    rsp_calm     = 1'b0;
    logic [TRACK_W-1:0]    head_start   = START_RESET;

    elevator_seek_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    elevator_seek_scheduler_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // result side holds rsp_ready low for a random stall after each beat, none when rsp_calm is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_hold  <= 0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            hold_draw = rsp_calm ? 0 : $urandom_range(0, 9);
            rsp_hold  <= hold_draw;
            rsp_ready <= (hold_draw == 0);
        end
        else if (rsp_hold > 0)
        begin
            rsp_hold  <= rsp_hold - 1;
            rsp_ready <= (rsp_hold == 1);
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [TRACK_W-1:0] track, input logic last);
        int gap;
        gap = req_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        req.track  <= track;
        req.last   <= last;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper data bits carry noise, only the low track bits should land
    task automatic set_start(input logic [TRACK_W-1:0] value);
        logic [APB_DATA_W-1:0] noise;
        noise = $urandom();
        apb_write(ADDR_START_TRACK, (noise << TRACK_W) | APB_DATA_W'(value));
        head_start = value;
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [TRACK_W-1:0] draw_track();
        int near;
        case ($urandom_range(0, 3))
            0: return TRACK_W'($urandom_range(0, int'(TRACK_TOP)));
            1:
            begin
                near = int'(head_start) + $urandom_range(0, 40) - 20;
                if (near < 0)
                    near = 0;
                if (near > int'(TRACK_TOP))
                    near = int'(TRACK_TOP);
                return TRACK_W'(near);
            end
            2: return head_start + TRACK_W'($urandom_range(0, 3) * 8);
            default:
            begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return TRACK_TOP;
                    default: return head_start;
                endcase
            end
        endcase
    endfunction

    function automatic logic [TRACK_W-1:0] draw_start();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return TRACK_TOP;
            2: return START_RESET;
            default: return TRACK_W'($urandom_range(0, int'(TRACK_TOP)));
        endcase
    endfunction

    initial
    begin
        int sent;
        int batch_len;
        int size_pick;
        int cut;
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single track below the reset start
        send_request('0, 1'b1);
        // extremes, a duplicate of an upward track and a track equal to the head
        send_request(TRACK_TOP, 1'b0);
        send_request(12'd200, 1'b0);
        send_request(12'd200, 1'b0);
        send_request(START_RESET, 1'b0);
        send_request(12'd50, 1'b0);
        send_request('0, 1'b1);
        // start changed in the middle of a batch, plus a write to an unused address
        settle();
        send_request(TRACK_TOP, 1'b0);
        settle();
        set_start('0);
        apb_write(ADDR_UNUSED, APB_DATA_W'(TRACK_TOP));
        send_request('0, 1'b1);
        // full store, the closing beat itself dropped
        settle();
        set_start(TRACK_TOP);
        for (i = 0; i < MAX_REQUESTS + 1; i++)
            send_request(draw_track(), i == MAX_REQUESTS);
        settle();
        set_start(START_RESET);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            size_pick = $urandom_range(0, 15);
            if (size_pick == 0)
                batch_len = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 3);
            else if (size_pick < 4)
                batch_len = $urandom_range(7, MAX_REQUESTS);
            else
                batch_len = $urandom_range(1, 6);
            req_calm  = ($urandom_range(0, 3) == 0);
            rsp_calm <= ($urandom_range(0, 3) == 0);
            cut = (batch_len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, batch_len - 1)
                                                               : 0;
            for (i = 0; i < batch_len; i++)
            begin
                if (cut != 0 && i == cut)
                begin
                    settle();
                    set_start(draw_start());
                end
                send_request(draw_track(), i == batch_len - 1);
            end
            sent += batch_len;
            if ($urandom_range(0, 3) == 0)
            begin
                settle();
                if ($urandom_range(0, 4) == 0)
                    apb_write(ADDR_UNUSED, $urandom());
                set_start(draw_start());
            end
        end

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
